FILE: rtl/ddo_pkg.sv
`timescale 1ns / 1ps
package ddo_pkg;

    // Number of CORDIC rotations used for the heading sine and cosine.
    localparam int TRIG_STEPS = 24;

    // Fixed-point angle constants.
    localparam logic [30:0]        TWO_PI_Q28        = 31'd1686629713;
    localparam logic [26:0]        TWO_PI_Q24        = 27'd105414357;
    localparam logic signed [34:0] HALF_PI_Q30       = 35'sd1686629713;
    localparam logic signed [34:0] PI_Q30            = 35'sd3373259426;
    localparam logic signed [34:0] THREE_HALF_PI_Q30 = 35'sd5059889139;
    localparam logic signed [34:0] TWO_PI_Q30        = 35'sd6746518852;
    localparam logic signed [32:0] CORDIC_GAIN_Q30   = 33'sd652032874;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_BASE   = 2'd1;
    localparam logic [1:0] REG_TICKS  = 2'd2;

    typedef struct packed {
        logic signed [31:0] left_count;
        logic signed [31:0] right_count;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] x_position;
        logic signed [31:0] y_position;
        logic signed [31:0] heading_angle;
        logic signed [31:0] center_step;
    } t_out_item;

    // Arctangent of 2^-i in Q30 radians.
    function automatic logic [30:0] atan_q30(input logic [4:0] i);
        logic [30:0] v;
        unique case (i)
            5'd0:  v = 31'd843314857;
            5'd1:  v = 31'd497837829;
            5'd2:  v = 31'd263043837;
            5'd3:  v = 31'd133525159;
            5'd4:  v = 31'd67021687;
            5'd5:  v = 31'd33543516;
            5'd6:  v = 31'd16775851;
            5'd7:  v = 31'd8388437;
            5'd8:  v = 31'd4194283;
            5'd9:  v = 31'd2097149;
            5'd10: v = 31'd1048576;
            5'd11: v = 31'd524288;
            5'd12: v = 31'd262144;
            5'd13: v = 31'd131072;
            5'd14: v = 31'd65536;
            5'd15: v = 31'd32768;
            5'd16: v = 31'd16384;
            5'd17: v = 31'd8192;
            5'd18: v = 31'd4096;
            5'd19: v = 31'd2048;
            5'd20: v = 31'd1024;
            5'd21: v = 31'd512;
            5'd22: v = 31'd256;
            5'd23: v = 31'd128;
            5'd24: v = 31'd64;
            5'd25: v = 31'd32;
            5'd26: v = 31'd16;
            5'd27: v = 31'd8;
            5'd28: v = 31'd4;
            5'd29: v = 31'd2;
            5'd30: v = 31'd1;
            5'd31: v = 31'd0;
        endcase
        return v;
    endfunction

    // Saturate a wide signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/differential_drive_odometry.sv
`timescale 1ns / 1ps
// Differential-drive wheel odometry. Each input item carries absolute left and right encoder
// counts; the block turns the tick deltas into wheel distances, advances the pose along the old
// heading and returns the new x, y, heading and the center step as one result item. All work
// runs on one bit-serial shift-add multiplier, one bit-serial restoring divider and one
// iterative CORDIC rotator, so an item is finished before the next one is accepted. The steps
// are: two wheel passes of a multiply by the radius, a multiply by 2*pi and a divide by the
// ticks per revolution, then the heading reduction, the CORDIC rotations, two multiplies
// for the position steps and a divide for the heading step. A finished result waits in an
// output register while the next item is taken. Registers sit at byte addresses 0 (wheel
// radius), 4 (wheel base) and 8 (ticks per revolution); the user must write them only while
// the block is idle, and the block itself does not enforce it.
module differential_drive_odometry import ddo_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_MR   = 10'b00_0000_0010,
        S_MC   = 10'b00_0000_0100,
        S_DIV  = 10'b00_0000_1000,
        S_CEN  = 10'b00_0001_0000,
        S_MOD  = 10'b00_0010_0000,
        S_COR  = 10'b00_0100_0000,
        S_MUL  = 10'b00_1000_0000,
        S_HDIV = 10'b01_0000_0000,
        S_DONE = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic [6:0] r_cnt, n_cnt;
    logic r_side, r_axis;
    logic r_out_valid;
    t_out_item r_out;

    logic [15:0] r_radius, r_base, r_tpr;
    logic signed [31:0] r_last_l, r_last_r;
    logic signed [31:0] r_pose_x, r_pose_y, r_pose_h;

    logic r_dl_neg, r_dr_neg;
    logic [32:0] r_dr_mag;
    logic signed [31:0] r_dist_l, r_dist_r, r_center;
    logic r_diff_neg;
    logic [32:0] r_diff_mag;

    logic [79:0] r_acc, r_mcand;
    logic [31:0] r_mplier;
    logic [79:0] r_dvd;
    logic [27:0] r_rem;
    logic [26:0] r_dvs;

    logic signed [32:0] r_cx, r_cy;
    logic signed [34:0] r_cz;
    logic r_flip;
    logic signed [31:0] r_cos, r_sin;

    // Handshakes and register reads.
    logic w_in_acc, w_out_go, w_cfg_wr;
    assign w_in_acc = i_in_valid & (r_state == S_IDLE);
    assign w_out_go = (r_state == S_DONE) & (~r_out_valid | ~i_out_stall);
    assign w_cfg_wr = psel & penable & pwrite;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign pready = 1'b1;

    always_comb begin
        unique case (paddr[3:2])
            REG_RADIUS: prdata = {16'd0, r_radius};
            REG_BASE:   prdata = {16'd0, r_base};
            REG_TICKS:  prdata = {16'd0, r_tpr};
            default:    prdata = 32'd0;
        endcase
    end

    // Tick deltas; a count that fell is taken as a counter reset.
    logic signed [33:0] w_dl_raw, w_dr_raw, w_dl, w_dr;
    logic [32:0] w_dl_mag, w_dr_mag;
    assign w_dl_raw = 34'(i_in_data.left_count) - 34'(r_last_l);
    assign w_dr_raw = 34'(i_in_data.right_count) - 34'(r_last_r);
    assign w_dl = w_dl_raw[33] ? 34'(i_in_data.left_count) : w_dl_raw;
    assign w_dr = w_dr_raw[33] ? 34'(i_in_data.right_count) : w_dr_raw;
    assign w_dl_mag = w_dl[33] ? 33'(-w_dl) : 33'(w_dl);
    assign w_dr_mag = w_dr[33] ? 33'(-w_dr) : 33'(w_dr);

    // Effective divisors; zero is treated as one.
    logic [15:0] w_n_eff, w_b_eff;
    assign w_n_eff = (r_tpr == 16'd0) ? 16'd1 : r_tpr;
    assign w_b_eff = (r_base == 16'd0) ? 16'd1 : r_base;

    // Shift-add multiplier step, one multiplier bit a cycle.
    logic [79:0] w_mul_sum;
    assign w_mul_sum = r_acc + (r_mplier[0] ? r_mcand : 80'd0);

    // Restoring divider step, one quotient bit a cycle.
    logic [27:0] w_rem_sh, w_rem_nx;
    logic w_ge;
    logic [79:0] w_dvd_nx;
    assign w_rem_sh = {r_rem[26:0], r_dvd[79]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_dvs});
    assign w_rem_nx = w_ge ? (w_rem_sh - {1'b0, r_dvs}) : w_rem_sh;
    assign w_dvd_nx = {r_dvd[78:0], w_ge};

    // Wheel distance: round the Q28 quotient, clamp and apply the sign.
    logic w_side_neg;
    logic [80:0] w_round;
    logic [52:0] w_rnd_q;
    logic [31:0] w_limit, w_res, w_dist;
    assign w_side_neg = r_side ? r_dr_neg : r_dl_neg;
    assign w_round = {1'b0, w_dvd_nx} + 81'h800_0000;
    assign w_rnd_q = w_round[80:28];
    assign w_limit = w_side_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    assign w_res   = (w_rnd_q > {21'd0, w_limit}) ? w_limit : w_rnd_q[31:0];
    assign w_dist  = w_side_neg ? (32'd0 - w_res) : w_res;

    // Center step (truncated toward zero) and wheel difference.
    logic signed [32:0] w_sum, w_sum_adj, w_diff;
    logic signed [31:0] w_center;
    logic [32:0] w_diff_mag;
    logic [31:0] w_center_mag;
    assign w_sum = 33'(r_dist_l) + 33'(r_dist_r);
    assign w_sum_adj = w_sum + $signed({32'd0, w_sum[32]});
    assign w_center = 32'(w_sum_adj >>> 1);
    assign w_diff = 33'(r_dist_r) - 33'(r_dist_l);
    assign w_diff_mag = w_diff[32] ? 33'(-w_diff) : 33'(w_diff);
    assign w_center_mag = r_center[31] ? (32'd0 - r_center) : r_center;

    // Heading reduced into [0, 2*pi), moved to Q30 and folded into [-pi/2, pi/2].
    logic [31:0] w_h_mag;
    logic [26:0] w_mod_rem, w_m;
    logic signed [34:0] w_z0, w_zf;
    logic w_flip;
    assign w_h_mag = r_pose_h[31] ? (32'd0 - r_pose_h) : r_pose_h;
    assign w_mod_rem = w_rem_nx[26:0];
    assign w_m = (r_pose_h[31] && (w_mod_rem != 27'd0)) ? (TWO_PI_Q24 - w_mod_rem) : w_mod_rem;
    assign w_z0 = $signed({2'b00, w_m, 6'd0});

    always_comb begin
        w_flip = 1'b0;
        w_zf = w_z0;
        if (w_z0 >= THREE_HALF_PI_Q30) begin
            w_zf = w_z0 - TWO_PI_Q30;
        end else if (w_z0 > HALF_PI_Q30) begin
            w_zf = w_z0 - PI_Q30;
            w_flip = 1'b1;
        end
    end

    // One CORDIC rotation per cycle with floor shifts.
    logic [4:0] w_i;
    logic signed [32:0] w_xs, w_ys, w_cx_nx, w_cy_nx;
    logic signed [34:0] w_at, w_cz_nx;
    logic signed [31:0] w_cos, w_sin;
    logic [31:0] w_cos_mag, w_sin_mag;
    assign w_i  = r_cnt[4:0];
    assign w_xs = r_cx >>> w_i;
    assign w_ys = r_cy >>> w_i;
    assign w_at = $signed({4'd0, atan_q30(w_i)});

    always_comb begin
        if (!r_cz[34]) begin
            w_cx_nx = r_cx - w_ys;
            w_cy_nx = r_cy + w_xs;
            w_cz_nx = r_cz - w_at;
        end else begin
            w_cx_nx = r_cx + w_ys;
            w_cy_nx = r_cy - w_xs;
            w_cz_nx = r_cz + w_at;
        end
    end

    assign w_cos = r_flip ? 32'(-w_cx_nx) : 32'(w_cx_nx);
    assign w_sin = r_flip ? 32'(-w_cy_nx) : 32'(w_cy_nx);
    assign w_cos_mag = w_cos[31] ? (32'd0 - w_cos) : w_cos;
    assign w_sin_mag = r_sin[31] ? (32'd0 - r_sin) : r_sin;

    // Position step: signed product rounded from Q30, then saturating add.
    logic w_pneg;
    logic signed [63:0] w_p, w_step, w_pose_old;
    logic signed [31:0] w_pose_new;
    assign w_pneg = r_center[31] ^ (r_axis ? r_sin[31] : r_cos[31]);
    assign w_p = w_pneg ? -$signed(w_mul_sum[63:0]) : $signed(w_mul_sum[63:0]);
    assign w_step = (w_p + 64'sd536870912) >>> 30;
    assign w_pose_old = r_axis ? 64'(r_pose_y) : 64'(r_pose_x);
    assign w_pose_new = sat32(w_pose_old + w_step);

    // Heading step: rounded quotient of the wheel difference by the base.
    logic [56:0] w_hdvd;
    logic signed [58:0] w_hq_s, w_inc, w_h_sum;
    logic signed [31:0] w_h_new;
    assign w_hdvd = {r_diff_mag, 24'd0} + {42'd0, w_b_eff[15:1]};
    assign w_hq_s = $signed({2'b00, w_dvd_nx[56:0]});
    assign w_inc  = r_diff_neg ? -w_hq_s : w_hq_s;
    assign w_h_sum = 59'(r_pose_h) + w_inc;
    assign w_h_new = sat32(64'(w_h_sum));

    // Last cycle of each serial phase.
    logic w_last;
    always_comb begin
        unique case (r_state)
            S_MR:    w_last = (r_cnt == 7'd15);
            S_MC:    w_last = (r_cnt == 7'd30);
            S_DIV:   w_last = (r_cnt == 7'd79);
            S_MOD:   w_last = (r_cnt == 7'd31);
            S_COR:   w_last = (r_cnt == 7'(TRIG_STEPS - 1));
            S_MUL:   w_last = (r_cnt == 7'd31);
            S_HDIV:  w_last = (r_cnt == 7'd56);
            default: w_last = 1'b1;
        endcase
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_in_acc) n_state = S_MR;
            S_MR:   if (w_last) n_state = S_MC;
            S_MC:   if (w_last) n_state = S_DIV;
            S_DIV:  if (w_last) n_state = r_side ? S_CEN : S_MR;
            S_CEN:  n_state = S_MOD;
            S_MOD:  if (w_last) n_state = S_COR;
            S_COR:  if (w_last) n_state = S_MUL;
            S_MUL:  if (w_last && r_axis) n_state = S_HDIV;
            S_HDIV: if (w_last) n_state = S_DONE;
            S_DONE: if (w_out_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        n_cnt = w_last ? 7'd0 : (r_cnt + 7'd1);
    end

    // Control state, pose and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= 7'd0;
            r_side      <= 1'b0;
            r_axis      <= 1'b0;
            r_out_valid <= 1'b0;
            r_radius    <= 16'd1966;
            r_base      <= 16'd7864;
            r_tpr       <= 16'd720;
            r_last_l    <= '0;
            r_last_r    <= '0;
            r_pose_x    <= '0;
            r_pose_y    <= '0;
            r_pose_h    <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (w_cfg_wr) begin
                unique case (paddr[3:2])
                    REG_RADIUS: r_radius <= pwdata[15:0];
                    REG_BASE:   r_base   <= pwdata[15:0];
                    REG_TICKS:  r_tpr    <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (w_in_acc) begin
                r_last_l <= i_in_data.left_count;
                r_last_r <= i_in_data.right_count;
                r_side   <= 1'b0;
            end
            if ((r_state == S_DIV) && w_last) begin
                r_side <= 1'b1;
            end
            if ((r_state == S_COR) && w_last) begin
                r_axis <= 1'b0;
            end
            if ((r_state == S_MUL) && w_last) begin
                r_axis <= 1'b1;
                if (r_axis) begin
                    r_pose_y <= w_pose_new;
                end else begin
                    r_pose_x <= w_pose_new;
                end
            end
            if ((r_state == S_HDIV) && w_last) begin
                r_pose_h <= w_h_new;
            end
            if (w_out_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Serial datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_dl_neg <= w_dl[33];
                    r_dr_neg <= w_dr[33];
                    r_dr_mag <= w_dr_mag;
                    r_mcand  <= 80'(w_dl_mag);
                    r_mplier <= {16'd0, r_radius};
                    r_acc    <= 80'd0;
                end
            end
            S_MR, S_MC, S_MUL: begin
                if (!w_last) begin
                    r_acc    <= w_mul_sum;
                    r_mcand  <= {r_mcand[78:0], 1'b0};
                    r_mplier <= {1'b0, r_mplier[31:1]};
                end else if (r_state == S_MR) begin
                    r_mcand  <= w_mul_sum;
                    r_mplier <= {1'b0, TWO_PI_Q28};
                    r_acc    <= 80'd0;
                end else if (r_state == S_MC) begin
                    r_dvd <= w_mul_sum;
                    r_rem <= 28'd0;
                    r_dvs <= {11'd0, w_n_eff};
                end else if (!r_axis) begin
                    r_mcand  <= 80'(w_sin_mag);
                    r_mplier <= w_center_mag;
                    r_acc    <= 80'd0;
                end else begin
                    r_dvd <= {w_hdvd, 23'd0};
                    r_rem <= 28'd0;
                    r_dvs <= {11'd0, w_b_eff};
                end
            end
            S_DIV: begin
                r_dvd <= w_dvd_nx;
                r_rem <= w_rem_nx;
                if (w_last) begin
                    if (!r_side) begin
                        r_dist_l <= w_dist;
                        r_mcand  <= 80'(r_dr_mag);
                        r_mplier <= {16'd0, r_radius};
                        r_acc    <= 80'd0;
                    end else begin
                        r_dist_r <= w_dist;
                    end
                end
            end
            S_CEN: begin
                r_center   <= w_center;
                r_diff_neg <= w_diff[32];
                r_diff_mag <= w_diff_mag;
                r_dvd      <= {w_h_mag, 48'd0};
                r_rem      <= 28'd0;
                r_dvs      <= TWO_PI_Q24;
            end
            S_MOD: begin
                r_dvd <= w_dvd_nx;
                r_rem <= w_rem_nx;
                if (w_last) begin
                    r_cx   <= CORDIC_GAIN_Q30;
                    r_cy   <= 33'sd0;
                    r_cz   <= w_zf;
                    r_flip <= w_flip;
                end
            end
            S_COR: begin
                r_cx <= w_cx_nx;
                r_cy <= w_cy_nx;
                r_cz <= w_cz_nx;
                if (w_last) begin
                    r_cos    <= w_cos;
                    r_sin    <= w_sin;
                    r_mcand  <= 80'(w_cos_mag);
                    r_mplier <= w_center_mag;
                    r_acc    <= 80'd0;
                end
            end
            S_HDIV: begin
                r_dvd <= w_dvd_nx;
                r_rem <= w_rem_nx;
            end
            S_DONE: begin
                if (w_out_go) begin
                    r_out <= '{x_position: r_pose_x, y_position: r_pose_y,
                               heading_angle: r_pose_h, center_step: r_center};
                end
            end
            default: ;
        endcase
    end

    // An accepted item always starts the left wheel multiply.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_MR))
        else $error("accepted item did not start the wheel multiply");

    // The divider remainder stays below the divisor in every divide phase.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIV) || (r_state == S_MOD) || (r_state == S_HDIV))
        |-> (r_rem < {1'b0, r_dvs}))
        else $error("divider remainder not below divisor");

    // The phase counter never runs past the longest phase.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 7'd79)
        else $error("phase counter overran");

    // A result appears only after the sequencer reached its final state.
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside the final state");

endmodule

FILE: test/differential_drive_odometry_tb.sv
`timescale 1ns / 1ps
module differential_drive_odometry_tb;
    import ddo_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int HOLD_CYCLES    = 3000;
    localparam int DRAIN_CYCLES   = 600;
    localparam int PHASE_ITEMS    = 420;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    differential_drive_odometry uut (.*);

    // Clock.
    always #5 i_clk = ~i_clk;

    // Mirror of the configuration and pose.
    logic [15:0] radius_cfg;
    logic [15:0] base_cfg;
    logic [15:0] ticks_cfg;
    longint      prev_left;
    longint      prev_right;
    longint      pose_x;
    longint      pose_y;
    longint      pose_head;

    t_in_item  pending_items[$];
    t_out_item expected_poses[$];
    int        items_sent;
    int        poses_checked;
    int        errors;
    bit        done_stimulus;
    int        quiet_cycles;

    // Arctangent of 2^-i in Q30.
    longint arctan_tbl[32] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516, 16775851,
        8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072, 65536, 32768,
        16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0};

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Wheel distance in Q16.16, rounded half away from zero.
    function automatic longint wheel_travel(longint delta);
        logic [63:0] n, mag, prod, q, r, lim, res, a;
        bit neg;
        n = (ticks_cfg == 0) ? 64'd1 : 64'(ticks_cfg);
        neg = delta < 0;
        mag = neg ? 64'(-delta) : 64'(delta);
        prod = mag * 64'(radius_cfg);
        q = prod / n;
        r = prod % n;
        lim = neg ? 64'd2147483648 : 64'd2147483647;
        if (q >= 64'd2147483648) begin
            res = lim;
        end else begin
            a = q * 64'd1686629713 + (r * 64'd1686629713) / n;
            res = (a + 64'd134217728) >> 28;
            if (res > lim) res = lim;
        end
        return neg ? -longint'(res) : longint'(res);
    endfunction

    // Cosine and sine of the heading by rotation CORDIC in Q30.
    task automatic heading_trig(input longint h, output longint c, output longint s);
        longint m, z, x, y, xs, ys;
        bit flip;
        flip = 0;
        m = h % 64'sd105414357;
        if (m < 0) m += 64'sd105414357;
        z = m * 64;
        if (z >= 64'sd5059889139) begin
            z -= 64'sd6746518852;
        end else if (z > 64'sd1686629713) begin
            z -= 64'sd3373259426;
            flip = 1;
        end
        x = 64'sd652032874;
        y = 0;
        for (int i = 0; i < TRIG_STEPS && i < 32; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= arctan_tbl[i];
            end else begin
                x += ys; y -= xs; z += arctan_tbl[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    // Advance the mirrored pose by one sample and return the new pose.
    task automatic advance_pose(input t_in_item it, output t_out_item res);
        longint l, r, dl_t, dr_t, dl, dr, ctr, cs, sn, diff, inc;
        logic [63:0] b, mag, q;
        l = longint'(it.left_count);
        r = longint'(it.right_count);
        dl_t = l - prev_left;
        dr_t = r - prev_right;
        if (dl_t < 0) dl_t = l;
        if (dr_t < 0) dr_t = r;
        dl = wheel_travel(dl_t);
        dr = wheel_travel(dr_t);
        ctr = (dl + dr) / 2;
        heading_trig(pose_head, cs, sn);
        pose_x = clamp32(pose_x + ((ctr * cs + 64'sd536870912) >>> 30));
        pose_y = clamp32(pose_y + ((ctr * sn + 64'sd536870912) >>> 30));
        b = (base_cfg == 0) ? 64'd1 : 64'(base_cfg);
        diff = dr - dl;
        mag = diff < 0 ? 64'(-diff) : 64'(diff);
        q = ((mag << 24) + b / 2) / b;
        inc = diff < 0 ? -longint'(q) : longint'(q);
        pose_head = clamp32(pose_head + inc);
        prev_left = l;
        prev_right = r;
        res.x_position = pose_x[31:0];
        res.y_position = pose_y[31:0];
        res.heading_angle = pose_head[31:0];
        res.center_step = ctr[31:0];
    endtask

    // Sender: bursts of items with random gaps.
    int burst_left;
    int gap_left;
    always @(posedge i_clk) begin
        t_out_item exp_pose;
        t_in_item  nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) begin
                advance_pose(i_in_data, exp_pose);
                expected_poses.push_back(exp_pose);
                items_sent++;
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                nxt = pending_items.pop_front();
                i_in_data <= nxt;
                i_in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off.
    int  hold_left;
    bit  hold_done;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left <= 0;
            hold_done <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_poses.size() == 0) begin
                    $error("result item with no expectation");
                    errors++;
                end else begin
                    t_out_item e;
                    e = expected_poses.pop_front();
                    if (o_out_data.x_position !== e.x_position) begin
                        $error("x_position exp %0d got %0d", e.x_position,
                               o_out_data.x_position);
                        errors++;
                    end
                    if (o_out_data.y_position !== e.y_position) begin
                        $error("y_position exp %0d got %0d", e.y_position,
                               o_out_data.y_position);
                        errors++;
                    end
                    if (o_out_data.heading_angle !== e.heading_angle) begin
                        $error("heading_angle exp %0d got %0d", e.heading_angle,
                               o_out_data.heading_angle);
                        errors++;
                    end
                    if (o_out_data.center_step !== e.center_step) begin
                        $error("center_step exp %0d got %0d", e.center_step,
                               o_out_data.center_step);
                        errors++;
                    end
                    poses_checked++;
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_out_stall <= 1'b1;
            end else if (!hold_done && poses_checked == 60) begin
                hold_done <= 1;
                hold_left <= HOLD_CYCLES;
                i_out_stall <= 1'b1;
            end else if (poses_checked % 200 < 100) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    // Watchdog on cycles without any accepted item, delivered result or register access.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // One register write through the configuration port.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_RADIUS) radius_cfg = val[15:0];
        else if (idx == REG_BASE) base_cfg = val[15:0];
        else if (idx == REG_TICKS) ticks_cfg = val[15:0];
    endtask

    // Wait for the block to settle before touching the registers.
    task automatic wait_idle();
        while (pending_items.size() > 0 || i_in_valid || expected_poses.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Random encoder samples, mostly smooth motion with occasional resets and noise.
    longint gen_left;
    longint gen_right;
    task automatic queue_random(input int count);
        t_in_item it;
        int kind;
        for (int k = 0; k < count; k++) begin
            kind = $urandom_range(0, 19);
            if (kind < 14) begin
                gen_left += $urandom_range(0, 300);
                gen_right += $urandom_range(0, 300);
            end else if (kind < 16) begin
                gen_left += $urandom_range(0, 2000000);
                gen_right += $urandom;
            end else if (kind < 18) begin
                gen_left = $urandom_range(0, 1000);
                gen_right = gen_right - $urandom_range(1, 500);
            end else begin
                gen_left = longint'($signed($urandom));
                gen_right = longint'($signed($urandom));
            end
            gen_left = longint'($signed(gen_left[31:0]));
            gen_right = longint'($signed(gen_right[31:0]));
            it.left_count = gen_left[31:0];
            it.right_count = gen_right[31:0];
            pending_items.push_back(it);
        end
    endtask

    task automatic queue_pair(input logic [31:0] l, input logic [31:0] r);
        t_in_item it;
        it.left_count = l;
        it.right_count = r;
        pending_items.push_back(it);
    endtask

    initial begin
        radius_cfg = 16'd1966;
        base_cfg = 16'd7864;
        ticks_cfg = 16'd720;
        prev_left = 0;
        prev_right = 0;
        pose_x = 0;
        pose_y = 0;
        pose_head = 0;
        gen_left = 0;
        gen_right = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed samples at reset settings: straight runs, turns, resets, extremes.
        queue_pair(32'd0, 32'd0);
        queue_pair(32'd100, 32'd100);
        queue_pair(32'd100, 32'd400);
        queue_pair(32'd900, 32'd400);
        queue_pair(32'd50, 32'd450);
        queue_pair(32'd60, 32'd10);
        queue_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_pair(32'h8000_0000, 32'h8000_0000);
        queue_pair(32'h7FFF_FFFF, 32'h8000_0000);
        queue_pair(32'h8000_0000, 32'h7FFF_FFFF);
        queue_pair(32'hFFFF_FFFF, 32'h0000_0001);
        queue_pair(32'h0000_0000, 32'h7FFF_FFFF);
        for (int k = 0; k < 8; k++) queue_pair(32'(k * 50000), 32'(k * 90000));
        wait_idle();

        // Extreme settings, zero values and an unmapped register.
        write_reg(REG_RADIUS, 32'hFFFF_FFFF);
        write_reg(REG_BASE, 32'd1);
        write_reg(REG_TICKS, 32'd1);
        write_reg(2'd3, 32'hFFFF_FFFF);
        queue_pair(32'h7FFF_FFFF, 32'd0);
        queue_pair(32'h8000_0000, 32'h7FFF_FFFF);
        queue_pair(32'd5, 32'd3);
        queue_random(PHASE_ITEMS - 20);
        wait_idle();

        write_reg(REG_RADIUS, 32'd1);
        write_reg(REG_BASE, 32'd65535);
        write_reg(REG_TICKS, 32'd65535);
        queue_random(PHASE_ITEMS);
        wait_idle();

        write_reg(REG_RADIUS, 32'd0);
        write_reg(REG_BASE, 32'd0);
        write_reg(REG_TICKS, 32'd0);
        queue_random(60);
        wait_idle();

        write_reg(REG_RADIUS, 32'd3000);
        write_reg(REG_BASE, 32'd0);
        write_reg(REG_TICKS, 32'd0);
        queue_random(100);
        wait_idle();

        write_reg(REG_RADIUS, 32'd1966);
        write_reg(REG_BASE, 32'd7864);
        write_reg(REG_TICKS, 32'd720);
        queue_random(PHASE_ITEMS);
        wait_idle();

        write_reg(REG_RADIUS, 32'($urandom_range(1, 65535)));
        write_reg(REG_BASE, 32'($urandom_range(1, 65535)));
        write_reg(REG_TICKS, 32'($urandom_range(1, 4096)));
        queue_random(PHASE_ITEMS);
        wait_idle();

        $display("Sent %0d encoder items over seven register settings, checked %0d poses.",
                 items_sent, poses_checked);
        $display("Covered extreme counts, counter resets, zero settings and a long output hold.");
        if (errors == 0 && expected_poses.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
